>>> src/hmc_pkg.sv
// ----------------------------------------------------------------------------
// hmc_pkg
// Shared types, codes and the syndrome action table of the hamming (8,4) codec
// ----------------------------------------------------------------------------
package hmc_pkg;

    localparam int unsigned DATA_W   = 8;
    localparam int unsigned NIB_W    = 4;
    localparam int unsigned SYN_W    = 4;
    localparam int unsigned MAT_W    = 32;
    localparam int unsigned CNT_W    = 32;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned CFG_IDX_W = 8;

    localparam logic [MAT_W-1:0] GEN_RESET = 32'd2025116385;
    localparam logic [MAT_W-1:0] CHK_RESET = 32'd2216786910;

    typedef enum logic {
        OP_ENCODE = 1'b0,
        OP_DECODE = 1'b1
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK            = 2'd0,
        ST_CORRECTED     = 2'd1,
        ST_UNCORRECTABLE = 2'd2
    } t_status;

    localparam logic [CFG_IDX_W-1:0] CFG_GENERATOR = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHECK     = 8'd1;

    // action codes: 0..7 bit to flip, else one of these
    localparam logic [3:0] ACT_UNCORRECTABLE = 4'd9;
    localparam logic [3:0] ACT_CLEAN         = 4'd10;

    function automatic logic [3:0] syndrome_action(input logic [SYN_W-1:0] syn);
        logic [3:0] act;
        case (syn)
            4'd0:    act = ACT_CLEAN;
            4'd1:    act = 4'd4;
            4'd2:    act = 4'd5;
            4'd4:    act = 4'd6;
            4'd7:    act = 4'd3;
            4'd8:    act = 4'd7;
            4'd11:   act = 4'd2;
            4'd13:   act = 4'd1;
            4'd14:   act = 4'd0;
            default: act = ACT_UNCORRECTABLE;
        endcase
        return act;
    endfunction

endpackage

>>> src/hamming_8_4_codec.sv
// ----------------------------------------------------------------------------
// hamming_8_4_codec
// Hamming (8,4) encoder / decoder with programmable GF(2) matrices
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_valid / o_ready) carries an operation and a data byte;
//   encode takes the low nibble and returns the code byte, decode takes a code
//   byte and returns the repaired nibble with a status.
//   Output channel (o_valid / i_ready) returns one item per input item, with
//   the decoded, corrected and uncorrected counters as they stand after it.
//   Configuration channel (i_cfg_valid / o_cfg_ready) writes the generator
//   (index 0) or the transposed check matrix (index 1); other indexes are
//   ignored. Writes are always taken and belong to idle periods only.
//   Path: an accepted item sits in the input register, then the matrix
//   products, table lookup and counter update run in one pass into the
//   result register, which drives o_valid.
//   Throughput is one item per cycle while the receiver takes results.
//   When the receiver stalls, the result register holds and one further item
//   is taken into the input register before o_ready drops.
//   Synchronous reset clears the pipeline, the counters and loads the default
//   matrices.
// ----------------------------------------------------------------------------
module hamming_8_4_codec (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic                                i_operation,
    input  logic [hmc_pkg::DATA_W-1:0]          i_data_in,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic [hmc_pkg::DATA_W-1:0]          o_data_out,
    output logic [hmc_pkg::STATUS_W-1:0]        o_status,
    output logic [hmc_pkg::CNT_W-1:0]           o_decoded_count,
    output logic [hmc_pkg::CNT_W-1:0]           o_corrected_count,
    output logic [hmc_pkg::CNT_W-1:0]           o_uncorrected_count,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [hmc_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [hmc_pkg::MAT_W-1:0]           i_cfg_data
);

    logic [hmc_pkg::MAT_W-1:0]    r_gen;
    logic [hmc_pkg::MAT_W-1:0]    r_chk;

    logic                         r_s1_valid;
    hmc_pkg::t_op                 r_s1_op;
    logic [hmc_pkg::DATA_W-1:0]   r_s1_data;

    logic                         r_out_valid;
    hmc_pkg::t_op                 r_out_op;
    logic [hmc_pkg::DATA_W-1:0]   r_out_data;
    hmc_pkg::t_status             r_out_status;
    logic [hmc_pkg::CNT_W-1:0]    r_dec_cnt;
    logic [hmc_pkg::CNT_W-1:0]    r_cor_cnt;
    logic [hmc_pkg::CNT_W-1:0]    r_unc_cnt;

    logic                         out_load;
    logic                         in_take;
    logic [hmc_pkg::DATA_W-1:0]   code;
    logic [hmc_pkg::SYN_W-1:0]    syn;
    logic [3:0]                   act;
    logic [hmc_pkg::NIB_W-1:0]    flip;
    logic [hmc_pkg::DATA_W-1:0]   n_out_data;
    hmc_pkg::t_status             n_out_status;

    assign out_load    = r_s1_valid && (!r_out_valid || i_ready);
    assign o_ready     = !r_s1_valid || out_load;
    assign in_take     = i_valid && o_ready;
    assign o_cfg_ready = 1'b1;

    // generator rows and check rows selected by message / code bits
    always_comb begin
        code = '0;
        for (int i = 0; i < hmc_pkg::NIB_W; i++) begin
            if (r_s1_data[i]) begin
                code = code ^ r_gen[i*hmc_pkg::DATA_W +: hmc_pkg::DATA_W];
            end
        end
        syn = '0;
        for (int j = 0; j < hmc_pkg::DATA_W; j++) begin
            if (r_s1_data[j]) begin
                syn = syn ^ r_chk[j*hmc_pkg::SYN_W +: hmc_pkg::SYN_W];
            end
        end
    end

    assign act = hmc_pkg::syndrome_action(syn);

    always_comb begin
        flip = '0;
        // flips of parity positions fall outside the nibble
        if (act[3] == 1'b0 && act[2] == 1'b0) begin
            flip[act[1:0]] = 1'b1;
        end
    end

    always_comb begin
        n_out_status = hmc_pkg::ST_OK;
        n_out_data   = code;
        if (r_s1_op == hmc_pkg::OP_DECODE) begin
            if (act == hmc_pkg::ACT_UNCORRECTABLE) begin
                n_out_status = hmc_pkg::ST_UNCORRECTABLE;
                n_out_data   = {4'd0, r_s1_data[hmc_pkg::NIB_W-1:0]};
            end else if (act == hmc_pkg::ACT_CLEAN) begin
                n_out_data   = {4'd0, r_s1_data[hmc_pkg::NIB_W-1:0]};
            end else begin
                n_out_status = hmc_pkg::ST_CORRECTED;
                n_out_data   = {4'd0, r_s1_data[hmc_pkg::NIB_W-1:0] ^ flip};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gen <= hmc_pkg::GEN_RESET;
            r_chk <= hmc_pkg::CHK_RESET;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == hmc_pkg::CFG_GENERATOR) begin
                r_gen <= i_cfg_data;
            end else if (i_cfg_index == hmc_pkg::CFG_CHECK) begin
                r_chk <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_ready) begin
            r_s1_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_s1_op   <= hmc_pkg::t_op'(i_operation);
            r_s1_data <= i_data_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_dec_cnt   <= '0;
            r_cor_cnt   <= '0;
            r_unc_cnt   <= '0;
        end else begin
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
            if (out_load && r_s1_op == hmc_pkg::OP_DECODE) begin
                r_dec_cnt <= r_dec_cnt + 1'b1;
                if (n_out_status == hmc_pkg::ST_CORRECTED) begin
                    r_cor_cnt <= r_cor_cnt + 1'b1;
                end
                if (n_out_status == hmc_pkg::ST_UNCORRECTABLE) begin
                    r_unc_cnt <= r_unc_cnt + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_op     <= r_s1_op;
            r_out_data   <= n_out_data;
            r_out_status <= n_out_status;
        end
    end

    assign o_valid             = r_out_valid;
    assign o_data_out          = r_out_data;
    assign o_status            = r_out_status;
    assign o_decoded_count     = r_dec_cnt;
    assign o_corrected_count   = r_cor_cnt;
    assign o_uncorrected_count = r_unc_cnt;

    // encode results never report an error
    a_encode_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_op == hmc_pkg::OP_ENCODE) |-> (r_out_status == hmc_pkg::ST_OK))
        else $error("encode result with non-ok status");

    // decoded nibble carries no upper bits
    a_decode_nibble: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_op == hmc_pkg::OP_DECODE) |-> (r_out_data[7:4] == 4'd0))
        else $error("decode result has upper bits set");

    // each decode bumps the decoded counter by one
    a_decode_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_load && r_s1_op == hmc_pkg::OP_DECODE) |=>
            (r_dec_cnt == $past(r_dec_cnt) + 1'b1))
        else $error("decoded counter did not advance");

    // counters stay put unless a result is loaded
    a_count_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !out_load |=> ($stable(r_dec_cnt) && $stable(r_cor_cnt) && $stable(r_unc_cnt)))
        else $error("counter moved without a result");

    // input side only stalls when an item is held in the input register
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> (r_s1_valid && r_out_valid && !i_ready))
        else $error("input stalled without cause");

endmodule

>>> tb/tb_hamming_8_4_codec.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_hamming_8_4_codec
// Self-checking bench for the hamming (8,4) codec: every accepted item is run
// through a local GF(2) codec model and the result item is compared field by
// field, under random sender bursts, receiver stalls and matrix settings.
// ----------------------------------------------------------------------------
module tb_hamming_8_4_codec;

    localparam int unsigned CYCLE_LIMIT = 300000;
    localparam int unsigned IDLE_PAD    = 4;
    localparam int unsigned MAX_REPORTS = 10;

    localparam logic [hmc_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 8'hFE;

    // syndrome to action: bit to flip, or clean / uncorrectable
    localparam logic [3:0] SYN_ACTION_MAP [16] = '{
        hmc_pkg::ACT_CLEAN, 4'd4, 4'd5, hmc_pkg::ACT_UNCORRECTABLE,
        4'd6, hmc_pkg::ACT_UNCORRECTABLE, hmc_pkg::ACT_UNCORRECTABLE, 4'd3,
        4'd7, hmc_pkg::ACT_UNCORRECTABLE, hmc_pkg::ACT_UNCORRECTABLE, 4'd2,
        hmc_pkg::ACT_UNCORRECTABLE, 4'd1, 4'd0, hmc_pkg::ACT_UNCORRECTABLE
    };

    typedef enum logic [1:0] {
        RX_ALWAYS,
        RX_RANDOM,
        RX_PATTERN
    } t_rx_mode;

    typedef struct packed {
        logic [hmc_pkg::DATA_W-1:0]   data_out;
        logic [hmc_pkg::STATUS_W-1:0] status;
        logic [hmc_pkg::CNT_W-1:0]    decoded;
        logic [hmc_pkg::CNT_W-1:0]    corrected;
        logic [hmc_pkg::CNT_W-1:0]    uncorrected;
    } t_codec_result;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          i_valid = 1'b0;
    logic                          o_ready;
    logic                          i_operation = 1'b0;
    logic [hmc_pkg::DATA_W-1:0]    i_data_in = '0;
    logic                          o_valid;
    logic                          i_ready = 1'b0;
    logic [hmc_pkg::DATA_W-1:0]    o_data_out;
    logic [hmc_pkg::STATUS_W-1:0]  o_status;
    logic [hmc_pkg::CNT_W-1:0]     o_decoded_count;
    logic [hmc_pkg::CNT_W-1:0]     o_corrected_count;
    logic [hmc_pkg::CNT_W-1:0]     o_uncorrected_count;
    logic                          i_cfg_valid = 1'b0;
    logic                          o_cfg_ready;
    logic [hmc_pkg::CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [hmc_pkg::MAT_W-1:0]     i_cfg_data = '0;

    // local copy of the codec state
    logic [hmc_pkg::MAT_W-1:0] gen_mat = hmc_pkg::GEN_RESET;
    logic [hmc_pkg::MAT_W-1:0] chk_mat = hmc_pkg::CHK_RESET;
    logic [hmc_pkg::CNT_W-1:0] decoded_total = '0;
    logic [hmc_pkg::CNT_W-1:0] corrected_total = '0;
    logic [hmc_pkg::CNT_W-1:0] uncorrected_total = '0;

    t_codec_result codec_results_due [$];

    int unsigned fail_count = 0;
    int unsigned cycle_count = 0;
    int unsigned burst_left = 0;
    bit          sender_gaps = 1'b1;
    t_rx_mode    rx_mode = RX_ALWAYS;
    int unsigned hold_req = 0;
    int unsigned hold_left = 0;
    logic [15:0] rx_pattern = 16'b1110_1101_1100_1011;

    hamming_8_4_codec dut (.*);

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic logic [hmc_pkg::DATA_W-1:0] gf2_encode(
        input logic [hmc_pkg::NIB_W-1:0] nib);
        logic [hmc_pkg::DATA_W-1:0] code;
        code = '0;
        for (int i = 0; i < hmc_pkg::NIB_W; i++) begin
            if (nib[i]) begin
                code ^= gen_mat[i*8 +: 8];
            end
        end
        return code;
    endfunction

    function automatic logic [hmc_pkg::SYN_W-1:0] gf2_syndrome(
        input logic [hmc_pkg::DATA_W-1:0] code);
        logic [hmc_pkg::SYN_W-1:0] syn;
        syn = '0;
        for (int j = 0; j < hmc_pkg::DATA_W; j++) begin
            if (code[j]) begin
                syn ^= chk_mat[j*4 +: 4];
            end
        end
        return syn;
    endfunction

    // one codec operation, updating the local counters
    function automatic t_codec_result hamming_codec_step(input hmc_pkg::t_op op,
                                                         input logic [hmc_pkg::DATA_W-1:0] data);
        t_codec_result r;
        logic [3:0]    act;
        logic [7:0]    flip;
        r = '0;
        if (op == hmc_pkg::OP_ENCODE) begin
            r.data_out = gf2_encode(data[3:0]);
            r.status   = hmc_pkg::ST_OK;
        end else begin
            act = SYN_ACTION_MAP[gf2_syndrome(data)];
            decoded_total++;
            r.data_out = {4'b0000, data[3:0]};
            if (act == hmc_pkg::ACT_UNCORRECTABLE) begin
                uncorrected_total++;
                r.status = hmc_pkg::ST_UNCORRECTABLE;
            end else if (act == hmc_pkg::ACT_CLEAN) begin
                r.status = hmc_pkg::ST_OK;
            end else begin
                // a flip of a parity bit falls outside the nibble
                corrected_total++;
                flip       = 8'd1 << act[2:0];
                r.data_out = {4'b0000, data[3:0] ^ flip[3:0]};
                r.status   = hmc_pkg::ST_CORRECTED;
            end
        end
        r.decoded     = decoded_total;
        r.corrected   = corrected_total;
        r.uncorrected = uncorrected_total;
        return r;
    endfunction

    function automatic logic [hmc_pkg::DATA_W-1:0] inject_errors(
        input logic [hmc_pkg::DATA_W-1:0] code);
        int unsigned roll;
        int unsigned b1;
        int unsigned b2;
        roll = $urandom_range(0, 99);
        b1   = $urandom_range(0, 7);
        b2   = (b1 + $urandom_range(1, 7)) % 8;
        if (roll < 35) begin
            return code;
        end else if (roll < 80) begin
            return code ^ (8'd1 << b1);
        end
        return code ^ (8'd1 << b1) ^ (8'd1 << b2);
    endfunction

    task automatic note_failure(input string what, input logic [31:0] want,
                                input logic [31:0] got);
        fail_count++;
        if (fail_count <= MAX_REPORTS) begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $realtime, what, want, got);
        end
    endtask

    task automatic check_field(input string what, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            note_failure(what, want, got);
        end
    endtask

    always @(posedge i_clk) begin : result_check
        t_codec_result want;
        if (i_rst_n && o_valid && i_ready) begin
            if (codec_results_due.size() == 0) begin
                note_failure("unrequested result item, data_out", '0, o_data_out);
            end else begin
                want = codec_results_due.pop_front();
                check_field("data_out", want.data_out, o_data_out);
                check_field("status", want.status, o_status);
                check_field("decoded_count", want.decoded, o_decoded_count);
                check_field("corrected_count", want.corrected, o_corrected_count);
                check_field("uncorrected_count", want.uncorrected, o_uncorrected_count);
            end
        end
    end

    // receiver: its own stall pattern, plus long hold-offs on request
    always @(posedge i_clk) begin
        if (hold_req != 0) begin
            hold_left = hold_req;
            hold_req  = 0;
        end
        rx_pattern <= {rx_pattern[0], rx_pattern[15:1]};
        if (hold_left != 0) begin
            hold_left--;
            i_ready <= 1'b0;
        end else begin
            case (rx_mode)
                RX_ALWAYS: i_ready <= 1'b1;
                RX_RANDOM: i_ready <= ($urandom_range(0, 3) != 0);
                default:   i_ready <= rx_pattern[0];
            endcase
        end
    end

    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("tb_hamming_8_4_codec: errors");
        $finish;
    end

    // valid stays high into the next item unless a gap follows this burst
    task automatic send_item(input hmc_pkg::t_op op, input logic [hmc_pkg::DATA_W-1:0] data);
        int unsigned gap;
        i_valid     <= 1'b1;
        i_operation <= op;
        i_data_in   <= data;
        @(posedge i_clk);
        while (!o_ready) begin
            @(posedge i_clk);
        end
        codec_results_due.push_back(hamming_codec_step(op, data));
        if (burst_left != 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 24);
            if (sender_gaps) begin
                gap = $urandom_range(1, 7);
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    task automatic wait_idle();
        i_valid <= 1'b0;
        while (codec_results_due.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (IDLE_PAD) @(posedge i_clk);
    endtask

    task automatic write_register(input logic [hmc_pkg::CFG_IDX_W-1:0] idx,
                                  input logic [hmc_pkg::MAT_W-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) begin
            @(posedge i_clk);
        end
        case (idx)
            hmc_pkg::CFG_GENERATOR: gen_mat = value;
            hmc_pkg::CFG_CHECK:     chk_mat = value;
            default:                ;
        endcase
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // mostly encode / corrupted decode pairs, the rest loose items
    task automatic run_traffic(input int unsigned n_items);
        int unsigned               sent;
        int unsigned               pick;
        logic [hmc_pkg::NIB_W-1:0] nib;
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(0, 59) == 0) begin
                rx_mode     = t_rx_mode'($urandom_range(0, 2));
                sender_gaps = 1'($urandom_range(0, 1));
            end
            pick = $urandom_range(0, 99);
            if (pick < 60) begin
                nib = 4'($urandom_range(0, 15));
                send_item(hmc_pkg::OP_ENCODE, {4'($urandom_range(0, 15)), nib});
                send_item(hmc_pkg::OP_DECODE, inject_errors(gf2_encode(nib)));
                sent += 2;
            end else if (pick < 85) begin
                send_item(hmc_pkg::OP_DECODE, 8'($urandom_range(0, 255)));
                sent++;
            end else begin
                send_item(hmc_pkg::OP_ENCODE, 8'($urandom_range(0, 255)));
                sent++;
            end
        end
    endtask

    // upper bits must be ignored, counters must not move
    task automatic test_encode_edges();
        logic [hmc_pkg::DATA_W-1:0] vals [9];
        vals = '{8'h00, 8'hFF, 8'hF0, 8'h0F, 8'h01, 8'h12, 8'h24, 8'h48, 8'hA5};
        rx_mode     = RX_ALWAYS;
        sender_gaps = 1'b0;
        foreach (vals[k]) begin
            send_item(hmc_pkg::OP_ENCODE, vals[k]);
        end
        wait_idle();
    endtask

    // clean code, data bit and parity bit repairs, double errors, extremes
    task automatic test_decode_edges();
        logic [hmc_pkg::DATA_W-1:0] code;
        code = gf2_encode(4'hA);
        rx_mode = RX_PATTERN;
        send_item(hmc_pkg::OP_DECODE, code);
        send_item(hmc_pkg::OP_DECODE, code ^ 8'h01);
        send_item(hmc_pkg::OP_DECODE, code ^ 8'h08);
        send_item(hmc_pkg::OP_DECODE, code ^ 8'h40);
        send_item(hmc_pkg::OP_DECODE, code ^ 8'h80);
        send_item(hmc_pkg::OP_DECODE, code ^ 8'h03);
        send_item(hmc_pkg::OP_DECODE, code ^ 8'h90);
        send_item(hmc_pkg::OP_DECODE, 8'h00);
        send_item(hmc_pkg::OP_DECODE, 8'hFF);
        wait_idle();
    endtask

    task automatic test_matrix_settings();
        write_register(hmc_pkg::CFG_GENERATOR, '0);
        write_register(hmc_pkg::CFG_CHECK, '0);
        run_traffic(40);
        wait_idle();
        write_register(hmc_pkg::CFG_GENERATOR, '1);
        write_register(hmc_pkg::CFG_CHECK, '1);
        run_traffic(40);
        wait_idle();
        repeat (3) begin
            write_register(hmc_pkg::CFG_GENERATOR, $urandom);
            write_register(hmc_pkg::CFG_CHECK, $urandom);
            run_traffic(60);
            wait_idle();
        end
        write_register(hmc_pkg::CFG_GENERATOR, hmc_pkg::GEN_RESET);
        write_register(hmc_pkg::CFG_CHECK, hmc_pkg::CHK_RESET);
    endtask

    // writes to other indexes must leave both matrices alone
    task automatic test_unused_register();
        write_register(CFG_UNUSED, $urandom);
        write_register(8'($urandom_range(2, 255)), $urandom);
        run_traffic(20);
        wait_idle();
    endtask

    // receiver holds off while the sender keeps offering, so o_ready drops
    task automatic test_receiver_holdoff();
        rx_mode     = RX_ALWAYS;
        sender_gaps = 1'b0;
        hold_req    = 150;
        repeat (60) begin
            send_item(hmc_pkg::t_op'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
        end
        wait_idle();
    endtask

    task automatic test_random_traffic();
        repeat (11) begin
            rx_mode     = t_rx_mode'($urandom_range(0, 2));
            sender_gaps = 1'($urandom_range(0, 1));
            run_traffic(100);
        end
        wait_idle();
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_encode_edges();
        test_decode_edges();
        test_matrix_settings();
        test_unused_register();
        test_receiver_holdoff();
        test_random_traffic();

        if (codec_results_due.size() != 0) begin
            note_failure("outstanding result items", '0, codec_results_due.size());
        end
        if (fail_count == 0) begin
            $display("tb_hamming_8_4_codec: clean");
        end else begin
            $display("tb_hamming_8_4_codec: errors");
        end
        $finish;
    end

endmodule

>>> files.f
src/hmc_pkg.sv
src/hamming_8_4_codec.sv
tb/tb_hamming_8_4_codec.sv
